// ===== src/uudecode_line_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// uudecode line decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef UUDECODE_LINE_DECODER_DEFINES_SVH
`define UUDECODE_LINE_DECODER_DEFINES_SVH

// Same-cycle implication.
`define UUDL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uudl: assertion failed");

// Next-cycle implication.
`define UUDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uudl: assertion failed");

`endif

// ===== src/uudl_pkg.sv =====
// ----------------------------------------------------------------------------
// uudl_pkg
// Shared constants and the work entry passed from the front to the back end.
// ----------------------------------------------------------------------------
package uudl_pkg;

  localparam int unsigned CntW       = 24;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0]      CharLo    = 8'h20;
  localparam logic [7:0]      CharHi    = 8'h60;
  localparam logic [CntW-1:0] CapReset  = {CntW{1'b1}};

  localparam logic StOk  = 1'b0;
  localparam logic StErr = 1'b1;

  // Results of one accepted character: up to three data bytes, then
  // optionally the end result of the message.
  typedef struct packed {
    logic [7:0]      byte0;
    logic [7:0]      byte1;
    logic [7:0]      byte2;
    logic [1:0]      take;
    logic            has_end;
    logic            status;
    logic [CntW-1:0] count;
  } uudl_entry_t;

endpackage

// ===== src/uudl_front.sv =====
// ----------------------------------------------------------------------------
// uudl_front
// Classifies source characters, tracks line and group state and turns each
// accepted character into at most one queue entry.
// ----------------------------------------------------------------------------
`include "uudecode_line_decoder_defines.svh"

module uudl_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [uudl_pkg::CntW-1:0]  cfg_wr_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       in_eos_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output uudl_pkg::uudl_entry_t      q_entry_o
);

  typedef enum logic [1:0] {
    PhSeek = 2'd0,
    PhLine = 2'd1,
    PhDone = 2'd2
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [5:0]                left_q, left_d;
  logic [17:0]               grp_q, grp_d;
  logic [1:0]                fill_q, fill_d;
  logic [uudl_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [uudl_pkg::CntW-1:0] cap_q;

  logic                      accept;
  logic                      char_ok;
  logic [5:0]                dval;
  logic [uudl_pkg::CntW:0]   len_sum;
  logic                      ended;
  logic                      st;
  logic [1:0]                take;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign char_ok    = (in_byte_i > uudl_pkg::CharLo) && (in_byte_i <= uudl_pkg::CharHi);
  assign dval       = in_byte_i[5:0] - uudl_pkg::CharLo[5:0];
  assign len_sum    = {1'b0, cnt_q} + {{(uudl_pkg::CntW - 5){1'b0}}, dval};

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    grp_d     = grp_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    ended     = 1'b0;
    st        = uudl_pkg::StOk;
    take      = 2'd0;
    q_entry_o = '0;
    if (accept) begin
      case (phase_q)
        PhSeek, PhLine: begin
          if (char_ok) begin
            if (phase_q == PhSeek) begin
              if (dval == 6'd0) begin
                ended = 1'b1;
              end else if (len_sum > {1'b0, cap_q}) begin
                // Covers count overflow too, since capacity fits in CntW bits.
                ended = 1'b1;
                st    = uudl_pkg::StErr;
              end else begin
                left_d  = dval;
                grp_d   = '0;
                fill_d  = 2'd0;
                phase_d = PhLine;
              end
            end else if (fill_q != 2'd3) begin
              grp_d  = {grp_q[11:0], dval};
              fill_d = fill_q + 2'd1;
            end else begin
              take = (left_q < 6'd3) ? left_q[1:0] : 2'd3;
              q_entry_o.byte0 = {grp_q[17:12], grp_q[11:10]};
              q_entry_o.byte1 = {grp_q[9:6], grp_q[5:2]};
              q_entry_o.byte2 = {grp_q[1:0], dval};
              cnt_d  = cnt_q + {{(uudl_pkg::CntW - 2){1'b0}}, take};
              left_d = left_q - {4'd0, take};
              grp_d  = '0;
              fill_d = 2'd0;
              if (left_d == 6'd0) begin
                phase_d = PhSeek;
              end
            end
          end
          if (!ended && in_eos_i) begin
            ended = 1'b1;
            st    = (phase_d == PhLine) ? uudl_pkg::StErr : uudl_pkg::StOk;
          end
          q_entry_o.take    = take;
          q_entry_o.has_end = ended;
          q_entry_o.status  = st;
          q_entry_o.count   = (st == uudl_pkg::StErr) ? '0 : cnt_d;
          if (ended) begin
            if (in_eos_i) begin
              phase_d = PhSeek;
              left_d  = '0;
              grp_d   = '0;
              fill_d  = 2'd0;
              cnt_d   = '0;
            end else begin
              phase_d = PhDone;
            end
          end
        end
        default: begin
          // Finished: swallow input until the message ends.
          if (in_eos_i) begin
            phase_d = PhSeek;
            left_d  = '0;
            grp_d   = '0;
            fill_d  = 2'd0;
            cnt_d   = '0;
          end
        end
      endcase
    end
  end

  assign q_push_o = ended || (take != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSeek;
      left_q  <= '0;
      grp_q   <= '0;
      fill_q  <= 2'd0;
      cnt_q   <= '0;
      cap_q   <= uudl_pkg::CapReset;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      grp_q   <= grp_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      if (cfg_wr_en_i) begin
        cap_q <= cfg_wr_data_i;
      end
    end
  end

  `UUDL_ASSERT_IMPL(a_line_has_bytes, phase_q == PhLine, left_q != 6'd0)
  `UUDL_ASSERT_IMPL(a_no_push_when_full, q_push_o, !q_full_i)

endmodule

// ===== src/uudl_queue.sv =====
// ----------------------------------------------------------------------------
// uudl_queue
// Small FIFO of work entries between the front and the back end.
// ----------------------------------------------------------------------------
`include "uudecode_line_decoder_defines.svh"

module uudl_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  uudl_pkg::uudl_entry_t  push_entry_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   head_valid_o,
  output uudl_pkg::uudl_entry_t  head_entry_o
);

  uudl_pkg::uudl_entry_t            slots_q [uudl_pkg::QueueDepth];
  logic [uudl_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [uudl_pkg::QCntW-1:0]       count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o       = (count_q == uudl_pkg::QCntW'(uudl_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  `UUDL_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1)
  `UUDL_ASSERT_IMPL(a_count_bound, 1'b1,
                    count_q <= uudl_pkg::QCntW'(uudl_pkg::QueueDepth))

endmodule

// ===== src/uudl_back.sv =====
// ----------------------------------------------------------------------------
// uudl_back
// Expands queue entries into single results and holds them in the output
// register until the receiver takes them.
// ----------------------------------------------------------------------------
`include "uudecode_line_decoder_defines.svh"

module uudl_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  uudl_pkg::uudl_entry_t      head_entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_data_o,
  output logic                       out_is_data_o,
  output logic                       out_status_o,
  output logic [uudl_pkg::CntW-1:0]  out_count_o,
  output logic                       out_last_o
);

  logic [1:0]                idx_q;
  logic                      valid_q;
  logic [7:0]                data_q;
  logic                      is_data_q, status_q, last_q;
  logic [uudl_pkg::CntW-1:0] count_q;

  logic                      load;
  logic                      sel_data;
  logic                      final_res;
  logic [7:0]                sel_byte;

  assign load     = head_valid_i && (!valid_q || out_ready_i);
  assign sel_data = ({1'b0, idx_q} < {1'b0, head_entry_i.take});
  // The end result, or the last data byte when the entry has no end result.
  assign final_res = !sel_data ||
                     (!head_entry_i.has_end && (idx_q == head_entry_i.take - 2'd1));
  assign pop_o    = load && final_res;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_entry_i.byte0;
      2'd1:    sel_byte = head_entry_i.byte1;
      2'd2:    sel_byte = head_entry_i.byte2;
      default: sel_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= final_res ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q    <= sel_data ? sel_byte : 8'd0;
      is_data_q <= sel_data;
      status_q  <= sel_data ? uudl_pkg::StOk : head_entry_i.status;
      count_q   <= sel_data ? '0 : head_entry_i.count;
      last_q    <= final_res;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_data_o    = data_q;
  assign out_is_data_o = is_data_q;
  assign out_status_o  = status_q;
  assign out_count_o   = count_q;
  assign out_last_o    = last_q;

  `UUDL_ASSERT_IMPL(a_head_not_empty, head_valid_i,
                    (head_entry_i.take != 2'd0) || head_entry_i.has_end)
  `UUDL_ASSERT_IMPL(a_idx_in_entry, head_valid_i && (idx_q != 2'd0),
                    {1'b0, idx_q} <= {1'b0, head_entry_i.take})

endmodule

// ===== src/uudecode_line_decoder.sv =====
// ----------------------------------------------------------------------------
// uudecode_line_decoder
// Streaming uudecode: source characters in, decoded bytes and end results out.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries one source character, s_axis_tlast marks
// the last character of a message. Output stream: one result per transfer;
// tuser high means a decoded data byte, low means the end result of the
// message, which carries status (error high) and the total byte count.
// tlast marks the last result caused by one input character.
// cfg_wr_en_i/cfg_wr_data_i set the byte capacity per message; write only
// while the block is idle.
// The first result of a character is written into the queue, then into the
// output register. Input is taken one character per cycle while the
// four-entry queue between the classifier and the output stage has room; the
// output stage gives one result per cycle while the receiver is ready, so a
// character finishing a group gives up to four (three bytes and an end result).
// Reset returns to the start of a message and sets the capacity to all ones.
// When the receiver stalls, the output register holds, the queue fills and
// s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
module uudecode_line_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [uudl_pkg::CntW-1:0]  cfg_wr_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] in_byte
  input  logic                       s_axis_tlast,   // end_of_source
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [39:0]                m_axis_tdata,   // [7:0] data_byte, [8] status,
                                                     // [32:9] byte_count, [39:33] zero
  output logic                       m_axis_tuser,   // is_data
  output logic                       m_axis_tlast    // last
);

  logic                       q_full, q_push, q_pop, head_valid;
  uudl_pkg::uudl_entry_t      push_entry, head_entry;
  logic [7:0]                 out_data;
  logic                       out_status;
  logic [uudl_pkg::CntW-1:0]  out_count;

  uudl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .in_eos_i      (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  uudl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  uudl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_entry_i  (head_entry),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (out_data),
    .out_is_data_o (m_axis_tuser),
    .out_status_o  (out_status),
    .out_count_o   (out_count),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_count, out_status, out_data};

endmodule

// ===== tb/uudecode_line_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uudecode line decoder checker
// Watches the character and result streams of the decoder, keeps its own
// model of the line decoding state, and compares every result transfer with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module uudecode_line_decoder_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [uudl_pkg::CntW-1:0]  cfg_wr_data_i,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,
  input  logic                       s_axis_tlast,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [39:0]                m_axis_tdata,
  input  logic                       m_axis_tuser,
  input  logic                       m_axis_tlast,
  output int                         pending_o,
  output int                         fails_o
);

  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_LINE = 2'd1,
    PH_DONE = 2'd2
  } line_phase_e;

  typedef struct packed {
    logic [7:0]                data;
    logic                      is_data;
    logic                      status;
    logic [uudl_pkg::CntW-1:0] count;
    logic                      is_last;
  } uu_result_t;

  uu_result_t                decoded_q[$];
  uu_result_t                want;
  line_phase_e               phase;
  logic [5:0]                line_left;
  logic [17:0]               group_bits;
  logic [1:0]                group_fill;
  logic [uudl_pkg::CntW-1:0] out_count;
  logic [uudl_pkg::CntW-1:0] capacity;
  int                        fail_count = 0;

  assign fails_o = fail_count;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t checker: %s mismatch, got %0h expected %0h",
             $time, field, got, exp_val);
    fail_count++;
  endtask

  task automatic clear_message();
    phase      = PH_SEEK;
    line_left  = '0;
    group_bits = '0;
    group_fill = '0;
    out_count  = '0;
  endtask

  // Works out the results of one accepted character and queues them.
  task automatic decode_char(input logic [7:0] c, input logic eos);
    logic                      valid;
    logic [5:0]                d;
    logic [uudl_pkg::CntW:0]   sum;
    logic [7:0]                b [3];
    logic [5:0]                take;
    logic                      ended;
    logic                      st;
    int                        n;
    uu_result_t                r;

    valid = (c > uudl_pkg::CharLo) && (c <= uudl_pkg::CharHi);
    d     = 6'(c - uudl_pkg::CharLo);
    ended = 1'b0;
    st    = uudl_pkg::StOk;
    n     = 0;

    if (phase != PH_SEEK && phase != PH_LINE) begin
      if (eos) clear_message();
      return;
    end

    if (valid) begin
      if (phase == PH_SEEK) begin
        // The extra sum bit also catches a count that would wrap.
        sum = {1'b0, out_count} + {{(uudl_pkg::CntW - 5){1'b0}}, d};
        if (d == 6'd0) begin
          ended = 1'b1;
        end else if (sum > {1'b0, capacity}) begin
          ended = 1'b1;
          st    = uudl_pkg::StErr;
        end else begin
          line_left  = d;
          group_bits = '0;
          group_fill = '0;
          phase      = PH_LINE;
        end
      end else if (group_fill < 2'd3) begin
        group_bits = {group_bits[11:0], d};
        group_fill = group_fill + 2'd1;
      end else begin
        b[0] = {group_bits[17:12], group_bits[11:10]};
        b[1] = {group_bits[9:6], group_bits[5:2]};
        b[2] = {group_bits[1:0], d};
        take = (line_left < 6'd3) ? line_left : 6'd3;
        for (int k = 0; k < take; k++) begin
          r = '{data: b[k], is_data: 1'b1, status: uudl_pkg::StOk, count: '0,
                is_last: 1'b0};
          decoded_q.push_back(r);
          n++;
        end
        out_count  = out_count + {{(uudl_pkg::CntW - 6){1'b0}}, take};
        line_left  = line_left - take;
        group_bits = '0;
        group_fill = '0;
        if (line_left == 6'd0) phase = PH_SEEK;
      end
    end

    if (!ended && eos) begin
      ended = 1'b1;
      st    = (phase == PH_LINE) ? uudl_pkg::StErr : uudl_pkg::StOk;
    end

    if (ended) begin
      r = '{data: 8'h00, is_data: 1'b0, status: st,
            count: (st == uudl_pkg::StErr) ? '0 : out_count, is_last: 1'b0};
      decoded_q.push_back(r);
      n++;
      if (eos) clear_message();
      else phase = PH_DONE;
    end

    if (n > 0) decoded_q[decoded_q.size()-1].is_last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decoded_q.delete();
      clear_message();
      capacity  = uudl_pkg::CapReset;
      pending_o <= 0;
    end else begin
      if (cfg_wr_en_i) capacity = cfg_wr_data_i;

      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata[7:0] !== want.data)
            report_mismatch("data_byte", 32'(m_axis_tdata[7:0]), 32'(want.data));
          if (m_axis_tdata[8] !== want.status)
            report_mismatch("status", 32'(m_axis_tdata[8]), 32'(want.status));
          if (m_axis_tdata[32:9] !== want.count)
            report_mismatch("byte_count", 32'(m_axis_tdata[32:9]), 32'(want.count));
          if (m_axis_tdata[39:33] !== 7'd0)
            report_mismatch("tdata padding", 32'(m_axis_tdata[39:33]), '0);
          if (m_axis_tuser !== want.is_data)
            report_mismatch("is_data", 32'(m_axis_tuser), 32'(want.is_data));
          if (m_axis_tlast !== want.is_last)
            report_mismatch("last", 32'(m_axis_tlast), 32'(want.is_last));
        end
      end

      if (s_axis_tvalid && s_axis_tready) decode_char(s_axis_tdata, s_axis_tlast);

      pending_o <= decoded_q.size();
    end
  end

endmodule

// ===== tb/tb_uudecode_line_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uudecode_line_decoder
// Feeds the decoder with uuencoded messages: well-formed lines with random
// content, cut lines, overflowing lines and stray characters, under several
// capacity settings and random stalls on both streams. The checker does the
// comparison; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_uudecode_line_decoder;

  localparam int MaxCycles = 200000;
  localparam int TailCycles = 10;
  localparam int PhaseQuota = 32;
  localparam logic [7:0] ZeroLen = 8'h60;
  localparam logic [7:0] NewLine = 8'h0A;

  typedef enum int {
    MSG_GOOD,
    MSG_CUT_LINE,
    MSG_CUT_LENGTH,
    MSG_SEEK_END
  } msg_kind_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_wr_en_i = 1'b0;
  logic [uudl_pkg::CntW-1:0] cfg_wr_data_i = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = 8'h00;
  logic                      s_axis_tlast = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [39:0]               m_axis_tdata;
  logic                      m_axis_tuser;
  logic                      m_axis_tlast;
  logic                      gaps_on = 1'b1;
  int                        pending;
  int                        fails;
  int                        chars_sent = 0;
  int                        cycle_cnt = 0;

  uudecode_line_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  uudecode_line_decoder_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pending_o     (pending),
    .fails_o       (fails)
  );

  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !gaps_on || ($urandom_range(99) >= 33);
  end

  initial begin
    while (cycle_cnt < MaxCycles) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] data_char();
    return 8'(8'h21 + $urandom_range(63));
  endfunction

  // Characters the decoder skips: control codes, space and everything above
  // the backquote, which also exercises bit 7 of the input.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(3))
      0: return NewLine;
      1: return 8'h20;
      2: return 8'($urandom_range(32));
      default: return 8'($urandom_range(255, 97));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eos);
    while (gaps_on && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    if ((c > uudl_pkg::CharLo && c <= uudl_pkg::CharHi) || eos) chars_sent++;
  endtask

  task automatic send_text(input logic [7:0] c, input logic eos);
    if ($urandom_range(11) == 0) send_char(noise_char(), 1'b0);
    send_char(c, eos);
  endtask

  // One encoded line of n bytes. cut_at < 0 sends it whole; 0 ends the
  // message on the length character; k ends it on the k-th group character.
  task automatic send_line(input int n, input int cut_at);
    int nchars;
    nchars = ((n + 2) / 3) * 4;
    send_text(8'(8'h20 + n), cut_at == 0);
    if (cut_at == 0) return;
    for (int i = 1; i <= nchars; i++) begin
      send_text(data_char(), cut_at == i);
      if (cut_at == i) return;
    end
    if ($urandom_range(1) == 1) send_char(NewLine, 1'b0);
  endtask

  task automatic send_message(input msg_kind_e kind);
    int lines;
    int n;
    lines = $urandom_range(3);
    if (kind == MSG_CUT_LINE || kind == MSG_CUT_LENGTH) lines++;
    for (int i = 0; i < lines; i++) begin
      // Mostly short lines, now and then up to the longest one.
      n = ($urandom_range(9) == 0) ? $urandom_range(63, 1) : $urandom_range(12, 1);
      if (i == lines - 1 && kind == MSG_CUT_LINE)
        send_line(n, $urandom_range(((n + 2) / 3) * 4, 1));
      else if (i == lines - 1 && kind == MSG_CUT_LENGTH)
        send_line(n, 0);
      else
        send_line(n, -1);
    end
    case (kind)
      MSG_GOOD: begin
        case ($urandom_range(2))
          0: send_text(ZeroLen, 1'b1);
          1: begin
            send_text(ZeroLen, 1'b0);
            send_char(NewLine, 1'b1);
          end
          default: begin
            // Characters after the end result are ignored up to the last one.
            send_text(ZeroLen, 1'b0);
            repeat ($urandom_range(5, 1)) send_text(data_char(), 1'b0);
            send_text(data_char(), 1'b1);
          end
        endcase
      end
      MSG_SEEK_END: send_char(noise_char(), 1'b1);
      default: ;
    endcase
  endtask

  function automatic msg_kind_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 55) return MSG_GOOD;
    if (r < 70) return MSG_CUT_LINE;
    if (r < 82) return MSG_CUT_LENGTH;
    return MSG_SEEK_END;
  endfunction

  // Waits until every predicted result has been taken, then lets the
  // decoder settle with its input idle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [uudl_pkg::CntW-1:0] value);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  task automatic run_phase(input logic [uudl_pkg::CntW-1:0] cap, input logic gaps,
                           input logic hold_midway);
    int start;
    logic held;
    wait_idle();
    write_capacity(cap);
    gaps_on <= gaps;
    start = chars_sent;
    held = 1'b0;
    while (chars_sent - start < PhaseQuota) begin
      send_message(pick_kind());
      if (hold_midway && !held && chars_sent - start >= PhaseQuota / 2) begin
        wait_idle();
        held = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full group of all-ones characters; the message ends on the character
    // that completes the line, so three bytes and the end result come at once.
    send_char(8'h23, 1'b0);
    repeat (3) send_char(8'h5F, 1'b0);
    send_char(8'h5F, 1'b1);
    // Two-byte line with lowest and highest characters and skipped bytes.
    send_char(8'h22, 1'b0);
    send_char(8'h21, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h21, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(8'h21, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(ZeroLen, 1'b1);
    // Source ends inside a line, then on a length character.
    send_char(8'h21, 1'b0);
    send_char(8'h30, 1'b0);
    send_char(8'h31, 1'b1);
    send_char(8'h25, 1'b1);
    // Zero-length line, ignored characters, then the end of the source.
    send_char(ZeroLen, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h80, 1'b1);
    // Source ends while looking for a length character.
    send_char(NewLine, 1'b1);
    // No capacity: any nonzero line fails, an empty message still passes.
    wait_idle();
    write_capacity('0);
    send_char(8'h21, 1'b0);
    send_char(8'h50, 1'b1);
    send_char(ZeroLen, 1'b1);

    run_phase(uudl_pkg::CapReset, 1'b1, 1'b0);
    run_phase(uudl_pkg::CntW'($urandom_range(40, 4)), 1'b1, 1'b0);
    run_phase('0, 1'b1, 1'b0);
    run_phase(uudl_pkg::CntW'($urandom_range(24'hFFFFFF)), 1'b1, 1'b1);
    run_phase(uudl_pkg::CntW'($urandom_range(200, 60)), 1'b0, 1'b0);
    run_phase(uudl_pkg::CapReset, 1'b1, 1'b0);

    wait_idle();
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
